// ----- hdl/gpe_pkg.sv -----
// Shared types, constants and helpers for the gamepad event decoder.
package gpe_pkg;

    localparam int BUTTON_COUNT = 18;
    localparam int AXIS_COUNT   = 6;
    localparam int AXIS_W       = 16;
    localparam int PAD_BASE     = BUTTON_COUNT - 4;
    localparam int PAD_UP       = PAD_BASE + 0;
    localparam int PAD_RIGHT    = PAD_BASE + 1;
    localparam int PAD_DOWN     = PAD_BASE + 2;
    localparam int PAD_LEFT     = PAD_BASE + 3;
    localparam int BTN_IDX_W    = $clog2(BUTTON_COUNT);
    localparam int AXIS_IDX_W   = $clog2(AXIS_COUNT);
    localparam int CFG_IDX_W    = 8;

    localparam logic [7:0] KIND_BUTTON = 8'h01;
    localparam logic [7:0] KIND_AXIS   = 8'h02;
    localparam logic [7:0] BTN_RELEASE = 8'h00;
    localparam logic [7:0] BTN_PRESS   = 8'h01;

    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_REVERSE = 8'd1;

    localparam logic [7:0] AXIS_PAD_X = 8'd4;
    localparam logic [7:0] AXIS_PAD_Y = 8'd5;

    typedef logic [BUTTON_COUNT-1:0] btn_vec_t;
    typedef logic [AXIS_COUNT-1:0][AXIS_W-1:0] axis_vec_t;

    typedef struct packed {
        btn_vec_t  pending_buttons;
        btn_vec_t  current_buttons;
        btn_vec_t  previous_buttons;
        axis_vec_t pending_axes;
        axis_vec_t current_axes;
    } gpe_state_t;

    // When rev is set, negate with saturation of the most negative value; else pass v through.
    function automatic logic [AXIS_W-1:0] axis_rev(input logic [AXIS_W-1:0] v,
                                                  input logic rev);
        logic [AXIS_W-1:0] r;
        if (!rev)
            r = v;
        else if (v == {1'b1, {(AXIS_W-1){1'b0}}})
            r = {1'b0, {(AXIS_W-1){1'b1}}};
        else
            r = ~v + 1'b1;
        return r;
    endfunction

endpackage

// ----- hdl/gpe_next.sv -----
// Next-state logic: applies one event or latch to the decoder state.
module gpe_next (
    input  logic               func,
    input  logic [15:0]        event_value,
    input  logic [7:0]         event_kind,
    input  logic [7:0]         event_number,
    input  logic               precision_mode,
    input  gpe_pkg::gpe_state_t cur,
    output gpe_pkg::gpe_state_t nxt
);

    logic [gpe_pkg::AXIS_W-1:0] axis_val;
    logic                       axis_pos;
    logic                       axis_neg;

    always_comb
    begin
        if (precision_mode)
            axis_val = event_value;
        else
            axis_val = {{(gpe_pkg::AXIS_W-8){event_value[15]}}, event_value[15:8]};
        axis_neg = axis_val[gpe_pkg::AXIS_W-1];
        axis_pos = !axis_neg && (axis_val != '0);
    end

    always_comb
    begin
        nxt = cur;
        if (func)
        begin
            nxt.previous_buttons = cur.current_buttons;
            nxt.current_buttons  = cur.pending_buttons;
            nxt.current_axes     = cur.pending_axes;
        end
        else if (event_kind == gpe_pkg::KIND_BUTTON)
        begin
            if (event_number < 8'(gpe_pkg::PAD_BASE))
            begin
                if (event_value[7:0] == gpe_pkg::BTN_RELEASE)
                    nxt.pending_buttons[event_number[gpe_pkg::BTN_IDX_W-1:0]] = 1'b0;
                else if (event_value[7:0] == gpe_pkg::BTN_PRESS)
                    nxt.pending_buttons[event_number[gpe_pkg::BTN_IDX_W-1:0]] = 1'b1;
            end
        end
        else if (event_kind == gpe_pkg::KIND_AXIS)
        begin
            if (event_number < 8'(gpe_pkg::AXIS_COUNT))
            begin
                nxt.pending_axes[event_number[gpe_pkg::AXIS_IDX_W-1:0]] = axis_val;
                if (event_number == gpe_pkg::AXIS_PAD_X)
                begin
                    nxt.pending_buttons[gpe_pkg::PAD_RIGHT] = axis_pos;
                    nxt.pending_buttons[gpe_pkg::PAD_LEFT]  = axis_neg;
                end
                else if (event_number == gpe_pkg::AXIS_PAD_Y)
                begin
                    nxt.pending_buttons[gpe_pkg::PAD_DOWN] = axis_pos;
                    nxt.pending_buttons[gpe_pkg::PAD_UP]   = axis_neg;
                end
            end
        end
    end

endmodule

// ----- hdl/gamepad_event_decoder.sv -----
// The result of an accepted event beat is registered into the result beat.
// Throughput: one event per cycle; the output register is refilled in the
// same cycle it is drained, so input stalls only while a result waits.
// Reset: asynchronous, clears config, all button and axis state, and
// the output valid flag.
module gamepad_event_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [15:0] event_value,
    input  logic [7:0]  event_kind,
    input  logic [7:0]  event_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [gpe_pkg::BUTTON_COUNT-1:0] held_buttons,
    output logic [gpe_pkg::BUTTON_COUNT-1:0] pressed_buttons,
    output logic [gpe_pkg::BUTTON_COUNT-1:0] released_buttons,
    output logic signed [gpe_pkg::AXIS_W-1:0] axis_left_x,
    output logic signed [gpe_pkg::AXIS_W-1:0] axis_left_y,
    output logic signed [gpe_pkg::AXIS_W-1:0] axis_right_x,
    output logic signed [gpe_pkg::AXIS_W-1:0] axis_right_y,
    output logic signed [gpe_pkg::AXIS_W-1:0] axis_pad_x,
    output logic signed [gpe_pkg::AXIS_W-1:0] axis_pad_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic        cfg_data
);

    gpe_pkg::gpe_state_t state_reg;
    gpe_pkg::gpe_state_t state_next;
    logic precision_reg;
    logic y_reverse_reg;
    logic out_valid_reg;
    logic in_fire;

    gpe_pkg::btn_vec_t  held_reg, pressed_reg, released_reg;
    gpe_pkg::axis_vec_t axes_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    gpe_next u_next (
        .func           (func),
        .event_value    (event_value),
        .event_kind     (event_kind),
        .event_number   (event_number),
        .precision_mode (precision_reg),
        .cur            (state_reg),
        .nxt            (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            precision_reg <= 1'b0;
            y_reverse_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    gpe_pkg::CFG_PRECISION: precision_reg <= cfg_data;
                    gpe_pkg::CFG_Y_REVERSE: y_reverse_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_fire)
                state_reg <= state_next;
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            held_reg     <= state_next.current_buttons;
            pressed_reg  <= state_next.current_buttons & ~state_next.previous_buttons;
            released_reg <= state_next.previous_buttons & ~state_next.current_buttons;
            for (int i = 0; i < gpe_pkg::AXIS_COUNT; i++)
            begin
                // odd axes are the Y axes
                axes_reg[i] <= gpe_pkg::axis_rev(state_next.current_axes[i],
                                                 y_reverse_reg && (i % 2 == 1));
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign held_buttons     = held_reg;
    assign pressed_buttons  = pressed_reg;
    assign released_buttons = released_reg;
    assign axis_left_x      = axes_reg[0];
    assign axis_left_y      = axes_reg[1];
    assign axis_right_x     = axes_reg[2];
    assign axis_right_y     = axes_reg[3];
    assign axis_pad_x       = axes_reg[4];
    assign axis_pad_y       = axes_reg[5];

    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pressed_buttons & released_buttons) == '0))
        else $error("pressed and released overlap");

    a_release_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((released_buttons & held_buttons) == '0))
        else $error("released button still held");

    a_pad_x_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.pending_buttons[gpe_pkg::PAD_LEFT] &&
          state_reg.pending_buttons[gpe_pkg::PAD_RIGHT]))
        else $error("pad left and right both set");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("accepted beat produced no result");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while result stalled");

endmodule

// ----- bench/gpe_bench_pkg.sv -----
// Report type and scoreboard with a bit-level model of the event decoder.
package gpe_bench_pkg;

    typedef struct packed {
        gpe_pkg::btn_vec_t held;
        gpe_pkg::btn_vec_t pressed;
        gpe_pkg::btn_vec_t released;
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_x;
        logic [15:0] right_y;
        logic [15:0] pad_x;
        logic [15:0] pad_y;
    } pad_report_t;

    class decoder_scoreboard;

        gpe_pkg::btn_vec_t  pend_btn = '0;
        gpe_pkg::btn_vec_t  cur_btn  = '0;
        gpe_pkg::btn_vec_t  prev_btn = '0;
        logic signed [15:0] pend_axes [gpe_pkg::AXIS_COUNT] = '{default: '0};
        logic signed [15:0] cur_axes  [gpe_pkg::AXIS_COUNT] = '{default: '0};
        bit                 precision = 1'b0;
        bit                 y_rev     = 1'b0;

        pad_report_t        expected_reports [$];
        int                 events  = 0;
        int                 latches = 0;
        int                 checked = 0;
        int                 errors  = 0;

        function void write_reg(logic [gpe_pkg::CFG_IDX_W-1:0] index, logic data);
            if (index == gpe_pkg::CFG_PRECISION)
                precision = data;
            else if (index == gpe_pkg::CFG_Y_REVERSE)
                y_rev = data;
        endfunction

        function logic signed [15:0] flip_y(logic signed [15:0] a);
            if (!y_rev)
                return a;
            return (a == 16'sh8000) ? 16'sh7fff : -a;
        endfunction

        // Apply one accepted input beat and queue the report it produces.
        function void note_event(logic fn, logic [15:0] value, logic [7:0] kind,
                                 logic [7:0] number);
            logic signed [15:0] v;
            pad_report_t        r;
            events++;
            if (fn) begin
                latches++;
                prev_btn = cur_btn;
                cur_btn  = pend_btn;
                cur_axes = pend_axes;
            end else if (kind == gpe_pkg::KIND_BUTTON) begin
                if (number < gpe_pkg::PAD_BASE) begin
                    if (value[7:0] == gpe_pkg::BTN_RELEASE)
                        pend_btn[number[gpe_pkg::BTN_IDX_W-1:0]] = 1'b0;
                    else if (value[7:0] == gpe_pkg::BTN_PRESS)
                        pend_btn[number[gpe_pkg::BTN_IDX_W-1:0]] = 1'b1;
                end
            end else if (kind == gpe_pkg::KIND_AXIS && number < gpe_pkg::AXIS_COUNT) begin
                v = precision ? value : {{8{value[15]}}, value[15:8]};
                pend_axes[number[gpe_pkg::AXIS_IDX_W-1:0]] = v;
                if (number == gpe_pkg::AXIS_PAD_X) begin
                    pend_btn[gpe_pkg::PAD_RIGHT] = (v > 0);
                    pend_btn[gpe_pkg::PAD_LEFT]  = (v < 0);
                end else if (number == gpe_pkg::AXIS_PAD_Y) begin
                    pend_btn[gpe_pkg::PAD_DOWN] = (v > 0);
                    pend_btn[gpe_pkg::PAD_UP]   = (v < 0);
                end
            end
            r.held     = cur_btn;
            r.pressed  = cur_btn & ~prev_btn;
            r.released = prev_btn & ~cur_btn;
            r.left_x   = cur_axes[0];
            r.left_y   = flip_y(cur_axes[1]);
            r.right_x  = cur_axes[2];
            r.right_y  = flip_y(cur_axes[3]);
            r.pad_x    = cur_axes[4];
            r.pad_y    = flip_y(cur_axes[5]);
            expected_reports.insert(expected_reports.size(), r);
        endfunction

        function void compare_field(string name, logic [17:0] want,
                                    logic [17:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: %s mismatch, expected %h, got %h",
                             $time, name, want, got);
            end
        endfunction

        function void check_report(pad_report_t got);
            pad_report_t want;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: output beat with no report expected", $time);
                return;
            end
            want = expected_reports.pop_front();
            checked++;
            compare_field("held_buttons", want.held, got.held);
            compare_field("pressed_buttons", want.pressed, got.pressed);
            compare_field("released_buttons", want.released, got.released);
            compare_field("axis_left_x", 18'(want.left_x), 18'(got.left_x));
            compare_field("axis_left_y", 18'(want.left_y), 18'(got.left_y));
            compare_field("axis_right_x", 18'(want.right_x), 18'(got.right_x));
            compare_field("axis_right_y", 18'(want.right_y), 18'(got.right_y));
            compare_field("axis_pad_x", 18'(want.pad_x), 18'(got.pad_x));
            compare_field("axis_pad_y", 18'(want.pad_y), 18'(got.pad_y));
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

    endclass

endpackage

// ----- bench/gamepad_event_decoder_test.sv -----
// Top-level bench: drives events and register writes, checks every report beat.
module gamepad_event_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       FUNC_EVENT  = 1'b0;
    localparam logic       FUNC_LATCH  = 1'b1;
    localparam logic [7:0] KIND_NONE   = 8'h00;
    localparam logic [7:0] KIND_OTHER  = 8'hFF;
    localparam logic [7:0] BTN_OTHER   = 8'h02;
    localparam logic [gpe_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'd200;

    localparam int PHASE_ITEMS = 210;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        func = 1'b0;
    logic [15:0] event_value = '0;
    logic [7:0]  event_kind = '0;
    logic [7:0]  event_number = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [17:0] held_buttons;
    logic [17:0] pressed_buttons;
    logic [17:0] released_buttons;
    logic signed [15:0] axis_left_x;
    logic signed [15:0] axis_left_y;
    logic signed [15:0] axis_right_x;
    logic signed [15:0] axis_right_y;
    logic signed [15:0] axis_pad_x;
    logic signed [15:0] axis_pad_y;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic        cfg_data = 1'b0;

    gpe_bench_pkg::decoder_scoreboard sb = new;

    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    bit hold_req   = 1'b0;
    int holds_done = 0;
    int settings   = 1;

    gamepad_event_decoder i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .event_value      (event_value),
        .event_kind       (event_kind),
        .event_number     (event_number),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .held_buttons     (held_buttons),
        .pressed_buttons  (pressed_buttons),
        .released_buttons (released_buttons),
        .axis_left_x      (axis_left_x),
        .axis_left_y      (axis_left_y),
        .axis_right_x     (axis_right_x),
        .axis_right_y     (axis_right_y),
        .axis_pad_x       (axis_pad_x),
        .axis_pad_y       (axis_pad_y),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Monitor: registers, then inputs, then reports, all sampled at the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_event(func, event_value, event_kind, event_number);
            if (out_valid && out_ready)
                sb.check_report('{held: held_buttons, pressed: pressed_buttons,
                                  released: released_buttons, left_x: axis_left_x,
                                  left_y: axis_left_y, right_x: axis_right_x,
                                  right_y: axis_right_y, pad_x: axis_pad_x,
                                  pad_y: axis_pad_y});
        end
    end

    // Valid stays high across back-to-back beats; callers lower it.
    task automatic send_event(logic fn, logic [15:0] value, logic [7:0] kind,
                              logic [7:0] number);
        in_valid     <= 1'b1;
        func         <= fn;
        event_value  <= value;
        event_kind   <= kind;
        event_number <= number;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        int n;
        if (tx_idle_en && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_cfg(logic [gpe_pkg::CFG_IDX_W-1:0] index, logic data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // Drain: no input beat in flight, every report back. The extra edge lets
    // the monitor note a beat taken at the edge the caller returned on.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(logic prec, logic yrev);
        settle();
        write_cfg(gpe_pkg::CFG_PRECISION, prec, 1'b0);
        write_cfg(gpe_pkg::CFG_Y_REVERSE, yrev, 1'b1);
        settings++;
    endtask

    task automatic send_random_item();
        int          pick;
        logic        fn;
        logic [15:0] value;
        logic [7:0]  kind;
        logic [7:0]  number;
        pick   = $urandom_range(0, 99);
        fn     = FUNC_EVENT;
        value  = 16'($urandom);
        kind   = 8'($urandom);
        number = 8'($urandom);
        if (pick < 20)
            fn = FUNC_LATCH;
        else if (pick < 55)
        begin
            kind   = gpe_pkg::KIND_BUTTON;
            number = 8'($urandom_range(0, gpe_pkg::PAD_BASE - 1));
            if ($urandom_range(0, 9) != 0)
                value[7:0] = $urandom_range(0, 1) ? gpe_pkg::BTN_PRESS
                                                  : gpe_pkg::BTN_RELEASE;
        end
        else if (pick < 90)
        begin
            kind   = gpe_pkg::KIND_AXIS;
            number = 8'($urandom_range(0, gpe_pkg::AXIS_COUNT - 1));
            case ($urandom_range(0, 7))
                0: value = 16'h8000;
                1: value = 16'h7FFF;
                2: value = 16'h0000;
                3: value = 16'h00FF;
                default: ;
            endcase
        end
        sender_gap();
        send_event(fn, value, kind, number);
    endtask

    task automatic run_random_phase(bit quiet, bit with_hold);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i % 64 == 0)
            begin
                tx_idle_en = !quiet && ($urandom_range(0, 3) != 0);
                rx_idle_en = !quiet && ($urandom_range(0, 3) != 0);
            end
            if (with_hold && i == 40)
                hold_req = 1'b1;
            send_random_item();
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin : result_sink
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 11);
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no handshake for %0d cycles, %0d reports outstanding",
                 STALL_LIMIT, sb.outstanding());
        $display("gamepad_event_decoder_test NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Byte-wide axes, no reversal (reset values).
        send_event(FUNC_EVENT, {8'h00, gpe_pkg::BTN_PRESS}, gpe_pkg::KIND_BUTTON, 8'd0);
        send_event(FUNC_EVENT, {8'hFF, gpe_pkg::BTN_PRESS}, gpe_pkg::KIND_BUTTON, 8'd13);
        send_event(FUNC_EVENT, {8'h00, gpe_pkg::BTN_PRESS}, gpe_pkg::KIND_BUTTON, 8'd14);
        send_event(FUNC_EVENT, {8'h00, gpe_pkg::BTN_PRESS}, gpe_pkg::KIND_BUTTON, 8'd255);
        send_event(FUNC_EVENT, {8'h00, BTN_OTHER}, gpe_pkg::KIND_BUTTON, 8'd5);
        send_event(FUNC_EVENT, 16'h7FFF, gpe_pkg::KIND_AXIS, 8'd0);
        send_event(FUNC_EVENT, 16'h80FF, gpe_pkg::KIND_AXIS, 8'd1);
        send_event(FUNC_EVENT, 16'h0100, gpe_pkg::KIND_AXIS, gpe_pkg::AXIS_PAD_X);
        send_event(FUNC_EVENT, 16'hFF00, gpe_pkg::KIND_AXIS, gpe_pkg::AXIS_PAD_Y);
        send_event(FUNC_EVENT, 16'h1234, gpe_pkg::KIND_AXIS, 8'd6);
        send_event(FUNC_EVENT, 16'hFFFF, gpe_pkg::KIND_AXIS, 8'd255);
        send_event(FUNC_EVENT, {8'h00, gpe_pkg::BTN_PRESS}, KIND_NONE, 8'd3);
        send_event(FUNC_EVENT, 16'h7F00, KIND_OTHER, 8'd2);
        send_event(FUNC_LATCH, {8'h00, gpe_pkg::BTN_PRESS}, gpe_pkg::KIND_BUTTON, 8'd2);
        send_event(FUNC_EVENT, {8'h00, gpe_pkg::BTN_RELEASE}, gpe_pkg::KIND_BUTTON, 8'd0);
        // high byte zero clears both horizontal pad bits
        send_event(FUNC_EVENT, 16'h00FF, gpe_pkg::KIND_AXIS, gpe_pkg::AXIS_PAD_X);
        send_event(FUNC_LATCH, 16'hFFFF, KIND_OTHER, 8'hFF);
        send_event(FUNC_LATCH, 16'h0000, KIND_NONE, 8'h00);

        // Full-width axes with Y reversal; unknown register index must do nothing.
        settle();
        write_cfg(gpe_pkg::CFG_PRECISION, 1'b1, 1'b0);
        write_cfg(gpe_pkg::CFG_Y_REVERSE, 1'b1, 1'b0);
        write_cfg(CFG_UNUSED, 1'b0, 1'b1);
        settings++;
        send_event(FUNC_EVENT, 16'h8000, gpe_pkg::KIND_AXIS, 8'd1);
        send_event(FUNC_EVENT, 16'h7FFF, gpe_pkg::KIND_AXIS, 8'd3);
        send_event(FUNC_EVENT, 16'h8000, gpe_pkg::KIND_AXIS, gpe_pkg::AXIS_PAD_Y);
        send_event(FUNC_EVENT, 16'hFFFF, gpe_pkg::KIND_AXIS, 8'd2);
        send_event(FUNC_EVENT, 16'h0001, gpe_pkg::KIND_AXIS, gpe_pkg::AXIS_PAD_X);
        send_event(FUNC_LATCH, 16'h0000, KIND_NONE, 8'h00);
        send_event(FUNC_EVENT, 16'h0001, gpe_pkg::KIND_AXIS, gpe_pkg::AXIS_PAD_Y);
        send_event(FUNC_LATCH, 16'hFFFF, gpe_pkg::KIND_AXIS, 8'd5);

        program_regs(1'b1, 1'b0);
        run_random_phase(1'b0, 1'b0);
        program_regs(1'b0, 1'b1);
        run_random_phase(1'b0, 1'b0);
        program_regs(1'b1, 1'b1);
        run_random_phase(1'b0, 1'b1);
        program_regs(1'b0, 1'b0);
        run_random_phase(1'b1, 1'b0);

        settle();
        repeat (4) @(posedge clk);

        $display("drove %0d event beats (%0d latches) under %0d register settings,",
                 sb.events, sb.latches, settings);
        $display("%0d long stalls; checked %0d reports, %0d mismatches, %0d left over",
                 holds_done, sb.checked, sb.errors, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("gamepad_event_decoder_test OK");
        else
            $display("gamepad_event_decoder_test NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/gpe_pkg.sv
hdl/gpe_next.sv
hdl/gamepad_event_decoder.sv
bench/gpe_bench_pkg.sv
bench/gamepad_event_decoder_test.sv
